// ===== rtl/core/gorl_pkg.sv =====
// ----------------------------------------------------------------------------
// gorl_pkg
// Shared widths, request and status codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gorl_pkg;

  // Default grid geometry and per-cell capacity.
  localparam int GORL_GRID_ROWS     = 16;
  localparam int GORL_GRID_COLS     = 16;
  localparam int GORL_CELL_CAPACITY = 255;

  // Field widths.
  localparam int REQ_W     = 3;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int SLOT_W    = 8;
  localparam int POS_W     = 16;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 16;
  localparam int CELL_W    = 8;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Largest value a size register can hold.
  localparam int CFG_MAX = (2 ** CFG_W) - 1;

  // Configuration register indexes and reset value.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 5'd16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TOTAL  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // latch the request and read its cell
    logic cell_exec;    // finish a single-cell request
    logic walk_step;    // one step of the row-major walk
    logic walk_finish;  // publish the walk result
    logic clr_step;     // clear one count entry after reset
  } gorl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;     // clearing pass is on its final entry
    logic needs_walk;   // pending request must walk the grid
    logic walk_done;    // walk has hit its target or run out of cells
  } gorl_sts_t;

endpackage

// ===== rtl/core/grid_occupancy_rank_locator_top.sv =====
// ----------------------------------------------------------------------------
// grid_occupancy_rank_locator_top
// Per-cell occupant counter for a rows-by-columns grid with rank lookup.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low,
// and its single result appears on the out_ ports for exactly one cycle,
// marked by out_valid; the receiver cannot stall, so it must capture the
// result in that cycle. After reset the block clears its count memory one
// entry per cycle, and busy stays high until every entry is cleared, so
// the first request is taken only after that pass; size registers may be
// written during that time. Add, delete, clear, count query, and a total
// query while the whole grid is in use each read the cell count from the
// memory in the cycle that accepts them and evaluate it and write it back
// in the next. A total query on a reduced grid, and every locate request,
// walk the in-use cells in row-major order, reading one count per cycle
// from the single memory read port; a locate stops early, once it has read
// the cell that holds the requested occupant.
// The result strobe always comes in the cycle in which busy has just
// dropped, so the next request can be presented alongside it. Size
// registers must be written only while no request is in progress.
// ----------------------------------------------------------------------------
module grid_occupancy_rank_locator_top #(
  parameter int GRID_ROWS     = gorl_pkg::GORL_GRID_ROWS,
  parameter int GRID_COLS     = gorl_pkg::GORL_GRID_COLS,
  parameter int CELL_CAPACITY = gorl_pkg::GORL_CELL_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [gorl_pkg::REQ_W-1:0]      in_req_type,
  input  logic [gorl_pkg::ROW_W-1:0]      in_cell_row,
  input  logic [gorl_pkg::COL_W-1:0]      in_cell_column,
  input  logic [gorl_pkg::SLOT_W-1:0]     in_agent_slot,
  input  logic [gorl_pkg::POS_W-1:0]      in_ordered_position,
  // Result channel.
  output logic                            out_valid,
  output logic [gorl_pkg::STAT_W-1:0]     out_status,
  output logic [gorl_pkg::CNT_W-1:0]      out_count_value,
  output logic [gorl_pkg::ROW_W-1:0]      out_found_row,
  output logic [gorl_pkg::COL_W-1:0]      out_found_column,
  output logic [gorl_pkg::SLOT_W-1:0]     out_found_slot,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [gorl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gorl_pkg::CFG_W-1:0]      cfg_wdata
);
  import gorl_pkg::*;

  // The controller sequences each request; the datapath owns all storage.
  gorl_cmd_t cmd;
  gorl_sts_t sts;

  gorl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  gorl_dp #(
    .GRID_ROWS     (GRID_ROWS),
    .GRID_COLS     (GRID_COLS),
    .CELL_CAPACITY (CELL_CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_req_type         (in_req_type),
    .in_cell_row         (in_cell_row),
    .in_cell_column      (in_cell_column),
    .in_agent_slot       (in_agent_slot),
    .in_ordered_position (in_ordered_position),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_count_value     (out_count_value),
    .out_found_row       (out_found_row),
    .out_found_column    (out_found_column),
    .out_found_slot      (out_found_slot)
  );

endmodule

// ===== rtl/core/gorl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gorl_ctrl
// Sequencer: post-reset clearing pass, single-cell requests and grid walks.
// ----------------------------------------------------------------------------
module gorl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gorl_pkg::gorl_sts_t sts,
  output gorl_pkg::gorl_cmd_t cmd,
  output logic                busy
);
  import gorl_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CELL  = 2'd2;
  localparam logic [1:0] S_WALK  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.needs_walk ? S_WALK : S_CELL;
        end
      end
      S_CELL: begin
        cmd.cell_exec = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          cmd.walk_finish = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/gorl_dp.sv =====
// ----------------------------------------------------------------------------
// gorl_dp
// Count memory, running total, size registers, walk accumulator and the
// result register.
// ----------------------------------------------------------------------------
module gorl_dp #(
  parameter int GRID_ROWS     = gorl_pkg::GORL_GRID_ROWS,
  parameter int GRID_COLS     = gorl_pkg::GORL_GRID_COLS,
  parameter int CELL_CAPACITY = gorl_pkg::GORL_CELL_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gorl_pkg::gorl_cmd_t             cmd,
  output gorl_pkg::gorl_sts_t             sts,
  input  logic                            cfg_wr_en,
  input  logic [gorl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gorl_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [gorl_pkg::REQ_W-1:0]      in_req_type,
  input  logic [gorl_pkg::ROW_W-1:0]      in_cell_row,
  input  logic [gorl_pkg::COL_W-1:0]      in_cell_column,
  input  logic [gorl_pkg::SLOT_W-1:0]     in_agent_slot,
  input  logic [gorl_pkg::POS_W-1:0]      in_ordered_position,
  output logic                            out_valid,
  output logic [gorl_pkg::STAT_W-1:0]     out_status,
  output logic [gorl_pkg::CNT_W-1:0]      out_count_value,
  output logic [gorl_pkg::ROW_W-1:0]      out_found_row,
  output logic [gorl_pkg::COL_W-1:0]      out_found_column,
  output logic [gorl_pkg::SLOT_W-1:0]     out_found_slot
);
  import gorl_pkg::*;

  localparam int NUM_CELLS = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CAP_LIM   = (CELL_CAPACITY > 255) ? 255 : CELL_CAPACITY;
  localparam int MAX_R     = (GRID_ROWS > CFG_MAX) ? CFG_MAX : GRID_ROWS;
  localparam int MAX_C     = (GRID_COLS > CFG_MAX) ? CFG_MAX : GRID_COLS;
  localparam int SUM_BITS  = $clog2(MAX_R * MAX_C * CAP_LIM + 1);
  localparam int ACC_W     = (SUM_BITS > CNT_W) ? SUM_BITS : CNT_W;

  localparam logic [CELL_W-1:0] CAP_VAL = CELL_W'(CAP_LIM);

  // Size registers and their effective values.
  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] cols_r;
  logic [CFG_W-1:0] eff_rows;
  logic [CFG_W-1:0] eff_cols;
  logic             grid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_SIZE_RESET;
      cols_r <= CFG_SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_r <= cfg_wdata;
        CFG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_rows  = (32'(rows_r) > GRID_ROWS) ? CFG_W'(GRID_ROWS) : rows_r;
  assign eff_cols  = (32'(cols_r) > GRID_COLS) ? CFG_W'(GRID_COLS) : cols_r;
  assign grid_full = (32'(eff_rows) == GRID_ROWS) && (32'(eff_cols) == GRID_COLS);

  // Request decode at accept time.
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;

  assign in_inside = ({1'b0, in_cell_row} < eff_rows) && ({1'b0, in_cell_column} < eff_cols);
  assign in_addr   = in_inside ?
                     ADDR_W'(32'(in_cell_row) * GRID_COLS + 32'(in_cell_column)) : '0;

  assign sts.needs_walk = (in_req_type == REQ_LOCATE) ||
                          ((in_req_type == REQ_TOTAL) && !grid_full);

  logic [REQ_W-1:0]  req_r;
  logic [SLOT_W-1:0] slot_r;
  logic [POS_W-1:0]  pos_r;
  logic [ADDR_W-1:0] addr_r;
  logic              inside_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      slot_r   <= in_agent_slot;
      pos_r    <= in_ordered_position;
      addr_r   <= in_addr;
      inside_r <= in_inside;
    end
  end

  // Clearing pass counter.
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == ADDR_W'(NUM_CELLS - 1));

  // Walk issue side.
  logic [CFG_W-1:0]  wr_r;
  logic [CFG_W-1:0]  wc_r;
  logic              issue_active;
  logic              issue_go;
  logic [ADDR_W-1:0] walk_addr;

  assign issue_active = (wr_r < eff_rows) && (eff_cols != '0);

  // Count memory: one write port, one registered read port.
  logic [CELL_W-1:0] mem [NUM_CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Walk consume side.
  logic              found_r;
  logic              pv_r;
  logic [CFG_W-1:0]  pr_r;
  logic [CFG_W-1:0]  pc_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_sum;
  logic              hit;
  logic [ROW_W-1:0]  frow_r;
  logic [COL_W-1:0]  fcol_r;
  logic [SLOT_W-1:0] fslot_r;

  assign issue_go  = issue_active && !found_r;
  assign walk_addr = issue_active ?
                     ADDR_W'(32'(wr_r) * GRID_COLS + 32'(wc_r)) : '0;
  assign mem_raddr = cmd.load ? in_addr : walk_addr;

  assign acc_sum = acc_r + ACC_W'(rdata_r);
  assign hit     = pv_r && !found_r && (req_r == REQ_LOCATE) &&
                   (pos_r != '0) && (acc_sum >= ACC_W'(pos_r));

  assign sts.walk_done = found_r || (!issue_active && !pv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.walk_step) begin
      pv_r <= issue_go;
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr_r  <= '0;
      wc_r  <= '0;
      acc_r <= '0;
    end else if (cmd.walk_step) begin
      if (issue_go) begin
        pr_r <= wr_r;
        pc_r <= wc_r;
        if (wc_r + CFG_W'(1) == eff_cols) begin
          wc_r <= '0;
          wr_r <= wr_r + CFG_W'(1);
        end else begin
          wc_r <= wc_r + CFG_W'(1);
        end
      end
      if (hit) begin
        frow_r  <= pr_r[ROW_W-1:0];
        fcol_r  <= pc_r[COL_W-1:0];
        fslot_r <= SLOT_W'(pos_r - acc_r[CNT_W-1:0] - CNT_W'(1));
      end else if (pv_r && !found_r) begin
        acc_r <= acc_sum;
      end
    end
  end

  // Single-cell request evaluation, done the cycle after the read.
  logic [CNT_W-1:0]  total_r;
  logic [STAT_W-1:0] cell_status;
  logic [CNT_W-1:0]  cell_count;
  logic              cell_we;
  logic [CELL_W-1:0] cell_wdata;
  logic [CNT_W-1:0]  total_nxt;

  always_comb begin
    cell_status = ST_OK;
    cell_count  = '0;
    cell_we     = 1'b0;
    cell_wdata  = rdata_r;
    total_nxt   = total_r;
    case (req_r)
      REQ_ADD: begin
        if (!inside_r) begin
          cell_status = ST_RANGE;
        end else if (rdata_r >= CAP_VAL) begin
          cell_status = ST_FULL;
        end else begin
          cell_we    = 1'b1;
          cell_wdata = rdata_r + CELL_W'(1);
          total_nxt  = total_r + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (!inside_r) begin
          cell_status = ST_RANGE;
        end else if (slot_r >= rdata_r) begin
          cell_status = ST_NO_SLOT;
        end else begin
          cell_we    = 1'b1;
          cell_wdata = rdata_r - CELL_W'(1);
          total_nxt  = total_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        if (!inside_r) begin
          cell_status = ST_RANGE;
        end else begin
          cell_we    = 1'b1;
          cell_wdata = '0;
          total_nxt  = total_r - CNT_W'(rdata_r);
        end
      end
      REQ_COUNT: begin
        if (!inside_r) begin
          cell_status = ST_RANGE;
        end else begin
          cell_count = CNT_W'(rdata_r);
        end
      end
      REQ_TOTAL: begin
        // Only reached with the whole grid in use: the running total is exact.
        cell_count = total_r;
      end
      default: begin
        cell_status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.cell_exec) begin
      total_r <= total_nxt;
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.cell_exec && cell_we);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign mem_wdata = cmd.clr_step ? '0 : cell_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Result register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [SLOT_W-1:0] out_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.cell_exec || cmd.walk_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_exec) begin
      out_status_r <= cell_status;
      out_count_r  <= cell_count;
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_slot_r   <= '0;
    end else if (cmd.walk_finish) begin
      if (req_r == REQ_LOCATE) begin
        out_status_r <= found_r ? ST_OK : ST_NOT_FOUND;
        out_count_r  <= '0;
        out_row_r    <= found_r ? frow_r : '0;
        out_col_r    <= found_r ? fcol_r : '0;
        out_slot_r   <= found_r ? fslot_r : '0;
      end else begin
        out_status_r <= ST_OK;
        out_count_r  <= acc_r[CNT_W-1:0];
        out_row_r    <= '0;
        out_col_r    <= '0;
        out_slot_r   <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_count_value  = out_count_r;
  assign out_found_row    = out_row_r;
  assign out_found_column = out_col_r;
  assign out_found_slot   = out_slot_r;

endmodule

// ===== dv/grid_occupancy_rank_locator_top_test.sv =====
// ----------------------------------------------------------------------------
// grid_occupancy_rank_locator_top_test
// Self-checking bench for the grid occupancy counter with rank lookup.
// ----------------------------------------------------------------------------
// Drives add, delete, clear, count, total and locate requests through the
// start/busy request channel. A scoreboard keeps its own copy of the cell
// counts and the size registers, predicts each result when the request is
// accepted, and compares every strobed result against the oldest prediction.
// The run covers a short directed list, one cell filled past capacity, and
// random phases under several grid sizes and sender idle rates.
// ----------------------------------------------------------------------------
module grid_occupancy_rank_locator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gorl_pkg::*;

  localparam int NUM_CELLS    = GORL_GRID_ROWS * GORL_GRID_COLS;
  // A cell saturates at the capacity, but never above what eight bits hold.
  localparam int OCC_LIMIT    = (GORL_CELL_CAPACITY > 255) ? 255 : GORL_CELL_CAPACITY;
  // Worst case is under eight hundred requests that each walk the full grid
  // after long sender gaps, plus the clearing pass after reset; this
  // limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int REPORT_LINES = 30;
  localparam int DRAIN_CYCLES = 300;

  // Request codes that the block does not define; both must be refused.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  req_kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
  } occ_request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count_value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
  } occ_result_t;

  // The scoreboard owns the predicted grid state. A request is folded into
  // that state at the edge where it is accepted, which is also the order in
  // which the block applies it, so predictions line up with the results.
  class occupancy_board;
    bit [CELL_W-1:0] cell_occ [NUM_CELLS];
    int unsigned     rows_reg;
    int unsigned     cols_reg;
    occ_result_t     pending [$];
    int unsigned     mismatch_count;
    int unsigned     result_count;
    int unsigned     status_seen [5];

    function new();
      foreach (cell_occ[i]) cell_occ[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      rows_reg       = CFG_SIZE_RESET;
      cols_reg       = CFG_SIZE_RESET;
      mismatch_count = 0;
      result_count   = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, int unsigned value);
      if (idx == CFG_ROWS_IN_USE) begin
        rows_reg = value & CFG_MAX;
      end else begin
        cols_reg = value & CFG_MAX;
      end
    endfunction

    // A size register above the grid dimension acts as the full dimension.
    function int unsigned eff_rows();
      return (rows_reg > GORL_GRID_ROWS) ? GORL_GRID_ROWS : rows_reg;
    endfunction

    function int unsigned eff_cols();
      return (cols_reg > GORL_GRID_COLS) ? GORL_GRID_COLS : cols_reg;
    endfunction

    // Occupants of the cells currently in use; cells outside keep their
    // counts but do not take part in totals or locates.
    function int unsigned in_use_sum();
      int unsigned acc;
      acc = 0;
      for (int unsigned r = 0; r < eff_rows(); r++) begin
        for (int unsigned c = 0; c < eff_cols(); c++) begin
          acc += cell_occ[r * GORL_GRID_COLS + c];
        end
      end
      return acc;
    endfunction

    function void note_request(occ_request_t req);
      occ_result_t res;
      int unsigned nr, nc, idx, total, reached, prior;
      bit          in_area, done;
      res     = '0;
      nr      = eff_rows();
      nc      = eff_cols();
      in_area = (req.row < nr) && (req.col < nc);
      idx     = req.row * GORL_GRID_COLS + req.col;
      case (req.req_kind)
        REQ_ADD: begin
          if (!in_area) begin
            res.status = ST_RANGE;
          end else if (cell_occ[idx] >= OCC_LIMIT) begin
            res.status = ST_FULL;
          end else begin
            cell_occ[idx]++;
          end
        end
        REQ_DELETE: begin
          if (!in_area) begin
            res.status = ST_RANGE;
          end else if (req.slot >= cell_occ[idx]) begin
            res.status = ST_NO_SLOT;
          end else begin
            cell_occ[idx]--;
          end
        end
        REQ_CLEAR: begin
          if (!in_area) begin
            res.status = ST_RANGE;
          end else begin
            cell_occ[idx] = '0;
          end
        end
        REQ_COUNT: begin
          if (!in_area) begin
            res.status = ST_RANGE;
          end else begin
            res.count_value = CNT_W'(cell_occ[idx]);
          end
        end
        REQ_TOTAL: begin
          res.count_value = CNT_W'(in_use_sum());
        end
        REQ_LOCATE: begin
          total = in_use_sum();
          if (req.pos == 0 || req.pos > total) begin
            res.status = ST_NOT_FOUND;
          end else begin
            // Walk in row-major order until the running count reaches the
            // requested rank; the slot is the rank's offset into that cell.
            reached = 0;
            prior   = 0;
            done    = 1'b0;
            for (int unsigned r = 0; r < nr && !done; r++) begin
              for (int unsigned c = 0; c < nc && !done; c++) begin
                reached += cell_occ[r * GORL_GRID_COLS + c];
                if (reached >= req.pos) begin
                  res.row  = ROW_W'(r);
                  res.col  = COL_W'(c);
                  res.slot = SLOT_W'(req.pos - prior - 1);
                  done     = 1'b1;
                end else begin
                  prior = reached;
                end
              end
            end
          end
        end
        default: begin
          res.status = ST_RANGE;
        end
      endcase
      pending.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
      end
    endtask

    task check_result(occ_result_t got);
      occ_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no request pending", got.status, 0);
        return;
      end
      want = pending.pop_front();
      result_count++;
      if (want.status < 5) status_seen[want.status]++;
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.count_value !== want.count_value) begin
        report_mismatch("count_value", got.count_value, want.count_value);
      end
      if (got.row !== want.row) report_mismatch("found_row", got.row, want.row);
      if (got.col !== want.col) report_mismatch("found_column", got.col, want.col);
      if (got.slot !== want.slot) report_mismatch("found_slot", got.slot, want.slot);
    endtask
  endclass

  // Every block input starts at a known value.
  logic                 clk                 = 1'b0;
  logic                 rst_n               = 1'b0;
  logic                 start               = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type         = '0;
  logic [ROW_W-1:0]     in_cell_row         = '0;
  logic [COL_W-1:0]     in_cell_column      = '0;
  logic [SLOT_W-1:0]    in_agent_slot       = '0;
  logic [POS_W-1:0]     in_ordered_position = '0;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_count_value;
  logic [ROW_W-1:0]     out_found_row;
  logic [COL_W-1:0]     out_found_column;
  logic [SLOT_W-1:0]    out_found_slot;
  logic                 cfg_wr_en           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index           = '0;
  logic [CFG_W-1:0]     cfg_wdata           = '0;

  occupancy_board   board = new();
  int unsigned      items_sent;
  int unsigned      settings_used;
  int unsigned      cycle_count;
  logic [ROW_W-1:0] hot_row;
  logic [COL_W-1:0] hot_col;

  grid_occupancy_rank_locator_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_cell_row         (in_cell_row),
    .in_cell_column      (in_cell_column),
    .in_agent_slot       (in_agent_slot),
    .in_ordered_position (in_ordered_position),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_count_value     (out_count_value),
    .out_found_row       (out_found_row),
    .out_found_column    (out_found_column),
    .out_found_slot      (out_found_slot),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Runaway guard: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver cannot stall, so every strobed result is taken at the edge
  // that closes its cycle. Outputs are read before that edge's updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      board.check_result({out_status, out_count_value, out_found_row,
                          out_found_column, out_found_slot});
    end
  end

  function automatic occ_request_t make_request(logic [REQ_W-1:0] kind, int unsigned row,
                                                int unsigned col, int unsigned slot,
                                                int unsigned pos);
    occ_request_t r;
    r.req_kind = kind;
    r.row      = ROW_W'(row);
    r.col      = COL_W'(col);
    r.slot     = SLOT_W'(slot);
    r.pos      = POS_W'(pos);
    return r;
  endfunction

  // Presents one request and holds it until the block takes it. Start is
  // left high afterwards; the next request or the next idle cycle decides
  // its value, so it never gets two updates in one time step.
  task automatic send_request(occ_request_t req, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_req_type         <= req.req_kind;
    in_cell_row         <= req.row;
    in_cell_column      <= req.col;
    in_agent_slot       <= req.slot;
    in_ordered_position <= req.pos;
    start               <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_request(req);
    items_sent++;
  endtask

  // Every request gives a result, so once nothing is pending the block is
  // idle; the caller can still ask for extra idle cycles before touching it.
  task automatic quiesce(int unsigned extra);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_sizes(int unsigned rows, int unsigned cols);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    board.set_size(CFG_ROWS_IN_USE, rows);
    cfg_index <= CFG_COLS_IN_USE;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    board.set_size(CFG_COLS_IN_USE, cols);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Random request shaped by the predicted state: most coordinates land in
  // the in-use area and often on one hot cell so counts build up, slots
  // mostly fall at or below the cell's count, and locate ranks mostly fall
  // within or just past the total.
  function automatic occ_request_t pick_request();
    occ_request_t r;
    int unsigned  nr, nc, pick, occ, total;
    nr   = board.eff_rows();
    nc   = board.eff_cols();
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.req_kind = REQ_ADD;
    end else if (pick < 50) begin
      r.req_kind = REQ_DELETE;
    end else if (pick < 54) begin
      r.req_kind = REQ_CLEAR;
    end else if (pick < 66) begin
      r.req_kind = REQ_COUNT;
    end else if (pick < 76) begin
      r.req_kind = REQ_TOTAL;
    end else if (pick < 97) begin
      r.req_kind = REQ_LOCATE;
    end else begin
      r.req_kind = ($urandom_range(1) == 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
    end
    if (nr != 0 && nc != 0 && $urandom_range(99) < 85) begin
      if ($urandom_range(1) == 1 && hot_row < nr && hot_col < nc) begin
        r.row = hot_row;
        r.col = hot_col;
      end else begin
        r.row = ROW_W'($urandom_range(nr - 1));
        r.col = COL_W'($urandom_range(nc - 1));
      end
    end else begin
      r.row = ROW_W'($urandom_range(15));
      r.col = COL_W'($urandom_range(15));
    end
    occ    = board.cell_occ[r.row * GORL_GRID_COLS + r.col];
    r.slot = ($urandom_range(99) < 80) ? SLOT_W'($urandom_range(occ))
                                       : SLOT_W'($urandom_range(255));
    total  = board.in_use_sum();
    case ($urandom_range(9))
      0:       r.pos = '0;
      1:       r.pos = POS_W'($urandom);
      default: r.pos = POS_W'($urandom_range(total + 1, 1));
    endcase
    return r;
  endfunction

  // One cell is driven to saturation and then pushed twice more so the
  // full-cell refusal is seen, followed by a count of that cell.
  task automatic fill_cell(int unsigned row, int unsigned col);
    int unsigned idx;
    idx = row * GORL_GRID_COLS + col;
    while (board.cell_occ[idx] < OCC_LIMIT) begin
      send_request(make_request(REQ_ADD, row, col, $urandom_range(255), $urandom), 33);
    end
    repeat (2) send_request(make_request(REQ_ADD, row, col, 0, 0), 33);
    send_request(make_request(REQ_COUNT, row, col, 0, 0), 0);
  endtask

  task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned idle_pct,
                           int unsigned count);
    quiesce(4);
    write_sizes(rows, cols);
    for (int unsigned k = 0; k < count; k++) begin
      // Move the hot cell now and then so several cells grow deep.
      if (k % 30 == 0) begin
        if (board.eff_rows() != 0 && board.eff_cols() != 0) begin
          hot_row = ROW_W'($urandom_range(board.eff_rows() - 1));
          hot_col = COL_W'($urandom_range(board.eff_cols() - 1));
        end else begin
          hot_row = ROW_W'($urandom_range(15));
          hot_col = COL_W'($urandom_range(15));
        end
      end
      send_request(pick_request(), idle_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the full 16 by 16 grid left by reset. The first
    // request waits out the clearing pass through the busy handshake.
    send_request(make_request(REQ_TOTAL, 0, 0, 0, 0), 0);
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 0), 0);        // rank zero
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 1), 0);        // empty grid
    send_request(make_request(REQ_ADD, 0, 0, 0, 0), 0);
    send_request(make_request(REQ_ADD, 0, 0, 0, 0), 0);
    send_request(make_request(REQ_ADD, 15, 15, 255, 16'hFFFF), 0);
    send_request(make_request(REQ_ADD, 7, 9, 0, 0), 0);
    send_request(make_request(REQ_COUNT, 0, 0, 0, 0), 0);
    send_request(make_request(REQ_COUNT, 15, 15, 0, 0), 0);
    send_request(make_request(REQ_TOTAL, 15, 15, 255, 16'hFFFF), 0);
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 1), 0);
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 2), 0);
    send_request(make_request(REQ_LOCATE, 15, 15, 255, 4), 0);
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 5), 0);        // one past the total
    send_request(make_request(REQ_LOCATE, 0, 0, 0, 16'hFFFF), 0);
    send_request(make_request(REQ_DELETE, 0, 0, 2, 0), 0);        // slot equal to count
    send_request(make_request(REQ_DELETE, 0, 0, 255, 0), 0);
    send_request(make_request(REQ_DELETE, 0, 0, 1, 0), 0);
    send_request(make_request(REQ_CLEAR, 7, 9, 0, 0), 0);
    send_request(make_request(REQ_COUNT, 7, 9, 0, 0), 0);
    send_request(make_request(REQ_SPARE_LO, 3, 3, 0, 1), 0);
    send_request(make_request(REQ_SPARE_HI, 15, 15, 255, 16'hFFFF), 0);
    send_request(make_request(REQ_CLEAR, 3, 3, 0, 0), 0);         // already empty
    send_request(make_request(REQ_DELETE, 3, 3, 0, 0), 0);        // empty cell

    // Saturate a cell in the first five rows and first three columns.
    fill_cell($urandom_range(4), $urandom_range(2));

    // Random phases. The receiver cannot hold results off, so phases meant
    // to stall it run without sender gaps instead.
    run_phase(16, 16, 0, 100);
    run_phase(1, 1, 74, 90);       // single cell, most coordinates land in it
    run_phase(31, 31, 0, 90);      // over-range sizes act as the full grid
    run_phase(5, 12, 33, 100);
    run_phase(0, 20, 74, 30);      // no cell in use at all
    run_phase(16, 3, 33, 80);

    quiesce(DRAIN_CYCLES);

    $display("Ran %0d requests under %0d grid sizes (reset, zero, one, partial, over-range).",
             items_sent, settings_used + 1);
    $display("Checked %0d results; ok/no-slot/not-found/full/range = %0d/%0d/%0d/%0d/%0d.",
             board.result_count, board.status_seen[0], board.status_seen[1],
             board.status_seen[2], board.status_seen[3], board.status_seen[4]);
    if (board.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
